@@ design/efsa_pkg.sv @@
`timescale 1ns / 1ps
// Package for the earliest-free-server assignment unit.
// Holds shared widths, payload structs and the server-number helper; no dependencies.
package efsa_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned SRV_W  = 5;
  localparam int unsigned DUR_W  = 16;
  localparam int unsigned TIME_W = 32;

  // Default server pool size and the configuration value after reset.
  localparam int unsigned MAX_SERVERS_DEF = 16;
  localparam logic [SRV_W-1:0] SERVER_COUNT_RST = SRV_W'(1);

  // Saturation value of all times.
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [SRV_W-1:0]  srv_num_t;

  // One job entering the unit.
  typedef struct packed {
    logic              new_case;
    logic [DUR_W-1:0]  duration;
  } in_t;

  // One assignment result leaving the unit.
  typedef struct packed {
    srv_num_t assigned_server;
    time_t    start_time;
    srv_num_t next_server;
  } out_t;

  // Zero-based server index to one-based server number, kept to the field width.
  function automatic srv_num_t srv_num(input logic [31:0] idx);
    logic [31:0] num;
    num = idx + 32'd1;
    return num[SRV_W-1:0];
  endfunction

endpackage

@@ design/efsa_min_tree.sv @@
`timescale 1ns / 1ps
// Combinational minimum tree over the server finish times.
// Depends on efsa_pkg for the time type; returns the lowest index holding the minimum.
module efsa_min_tree #(
  parameter int unsigned MaxServers = efsa_pkg::MAX_SERVERS_DEF,
  localparam int unsigned IdxW = (MaxServers > 1) ? $clog2(MaxServers) : 1,
  localparam int unsigned CntW = $clog2(MaxServers + 1)
) (
  input  efsa_pkg::time_t finish_i [MaxServers],
  input  logic [CntW-1:0] active_i,
  output logic [IdxW-1:0] min_idx_o
);

  localparam int unsigned Leaves = 1 << IdxW;
  localparam int unsigned Nodes  = 2 * Leaves - 1;

  // Heap-ordered nodes: node k has children 2k+1 and 2k+2, leaves sit at the end.
  efsa_pkg::time_t   nval [Nodes];
  logic              nvld [Nodes];
  logic [IdxW-1:0]   nidx [Nodes];

  // Leaves: only the first active_i servers take part.
  for (genvar i = 0; i < Leaves; i++) begin : g_leaf
    if (i < MaxServers) begin : g_used
      assign nvld[Leaves-1+i] = (32'(i) < 32'(active_i));
      assign nval[Leaves-1+i] = finish_i[i];
    end else begin : g_pad
      assign nvld[Leaves-1+i] = 1'b0;
      assign nval[Leaves-1+i] = '0;
    end
    assign nidx[Leaves-1+i] = IdxW'(i);
  end

  // Inner nodes: the left child holds lower indices, so it wins a tie.
  for (genvar k = 0; k < Leaves - 1; k++) begin : g_node
    logic take_l;
    assign take_l = nvld[2*k+1] &&
                    (!nvld[2*k+2] || (nval[2*k+1] <= nval[2*k+2]));
    assign nvld[k] = nvld[2*k+1] || nvld[2*k+2];
    assign nval[k] = take_l ? nval[2*k+1] : nval[2*k+2];
    assign nidx[k] = take_l ? nidx[2*k+1] : nidx[2*k+2];
  end

  assign min_idx_o = nidx[0];

endmodule

@@ design/earliest_free_server_assign_unit.sv @@
`timescale 1ns / 1ps
// Top level of the earliest-free-server assignment unit.
// Depends on efsa_pkg and efsa_min_tree.
//
// Usage:
//   Jobs arrive on the in_* valid/ready channel (new_case flag and duration).
//   Each job produces exactly one result on the out_* channel: the server it
//   got, its start time and the server the following job would get.
//   The server count is written on the cfg_* channel, which is always ready;
//   write it only while no job is in flight. Zero counts as one server and
//   values above MaxServers count as MaxServers.
//   Results pass through the input register A, the execute result B and the
//   output register C before out_valid_o rises. One job is taken per cycle
//   while the receiver keeps up; the finish-time update and the minimum tree
//   over all finish registers are combinational on the job held in A.
//   Reset clears all finish times, the fill count and the pipeline, and sets
//   the server count to one. When the receiver stalls, results back up into
//   the three pipeline registers and in_ready_o drops once they are all full.
module earliest_free_server_assign_unit #(
  parameter int unsigned MaxServers = efsa_pkg::MAX_SERVERS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  efsa_pkg::in_t           in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output efsa_pkg::out_t          out_data_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [efsa_pkg::SRV_W-1:0] cfg_data_i
);

  localparam int unsigned IdxW = (MaxServers > 1) ? $clog2(MaxServers) : 1;
  localparam int unsigned CntW = $clog2(MaxServers + 1);

  // Configuration register.
  logic [efsa_pkg::SRV_W-1:0] cfg_q;
  logic [CntW-1:0]            active;

  // Server state.
  efsa_pkg::time_t finish_q [MaxServers];
  efsa_pkg::time_t finish_d [MaxServers];
  logic [CntW-1:0] used_q, used_d;

  // Pipeline: input register A, execute result B, output register C.
  logic            a_valid_q, b_valid_q, c_valid_q;
  efsa_pkg::in_t   a_job_q;
  logic [IdxW-1:0] b_srv_q;
  efsa_pkg::time_t b_start_q;
  efsa_pkg::out_t  c_data_q;
  logic            a_adv, b_adv;

  // Selection logic.
  logic [IdxW-1:0] tree_idx;
  logic            filling;
  logic [IdxW-1:0] pick_idx;
  logic [IdxW-1:0] srv;
  efsa_pkg::time_t start;
  efsa_pkg::time_t finish_end;
  logic [efsa_pkg::TIME_W:0] sum;

  // Configuration write; the port is always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= efsa_pkg::SERVER_COUNT_RST;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  // Clamp the configured count into 1..MaxServers.
  always_comb begin
    if (cfg_q == '0) begin
      active = CntW'(1);
    end else if (32'(cfg_q) > 32'(MaxServers)) begin
      active = CntW'(MaxServers);
    end else begin
      active = CntW'(cfg_q);
    end
  end

  // Handshake flow through the three stages.
  assign b_adv      = b_valid_q && (!c_valid_q || out_ready_i);
  assign a_adv      = a_valid_q && (!b_valid_q || b_adv);
  assign in_ready_o = !a_valid_q || a_adv;

  // Earliest-finishing server among the active ones, on the current state.
  efsa_min_tree #(
    .MaxServers(MaxServers)
  ) u_min_tree (
    .finish_i (finish_q),
    .active_i (active),
    .min_idx_o(tree_idx)
  );

  // The server the next job gets from the current state. It serves as the
  // next-server figure of the job in B and as the choice for the job in A.
  assign filling  = (used_q < active);
  assign pick_idx = filling ? IdxW'(used_q) : tree_idx;

  // Execute the job in A: a new case starts over at server zero.
  always_comb begin
    if (a_job_q.new_case) begin
      srv   = '0;
      start = '0;
    end else begin
      srv   = pick_idx;
      start = filling ? '0 : finish_q[tree_idx];
    end
    sum        = {1'b0, start} + (efsa_pkg::TIME_W + 1)'(a_job_q.duration);
    finish_end = sum[efsa_pkg::TIME_W] ? efsa_pkg::TIME_MAX : sum[efsa_pkg::TIME_W-1:0];
  end

  // Next server state.
  always_comb begin
    for (int i = 0; i < MaxServers; i++) begin
      finish_d[i] = a_job_q.new_case ? '0 : finish_q[i];
      if (IdxW'(i) == srv) begin
        finish_d[i] = finish_end;
      end
    end
    if (a_job_q.new_case) begin
      used_d = CntW'(1);
    end else if (filling) begin
      used_d = used_q + CntW'(1);
    end else begin
      used_d = used_q;
    end
  end

  // State registers, updated when a job leaves A.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxServers; i++) begin
        finish_q[i] <= '0;
      end
      used_q <= '0;
    end else if (a_adv) begin
      finish_q <= finish_d;
      used_q   <= used_d;
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        a_valid_q <= in_valid_i;
      end
      if (!b_valid_q || b_adv) begin
        b_valid_q <= a_adv;
      end
      if (!c_valid_q || out_ready_i) begin
        c_valid_q <= b_adv;
      end
    end
  end

  // Pipeline payload registers.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      a_job_q <= in_data_i;
    end
    if (a_adv) begin
      b_srv_q   <= srv;
      b_start_q <= start;
    end
    if (b_adv) begin
      c_data_q.assigned_server <= efsa_pkg::srv_num(32'(b_srv_q));
      c_data_q.start_time      <= b_start_q;
      c_data_q.next_server     <= efsa_pkg::srv_num(32'(pick_idx));
    end
  end

  assign out_valid_o = c_valid_q;
  assign out_data_o  = c_data_q;

  // The fill count never passes the pool size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_q) <= 32'(MaxServers))
    else $error("server fill count beyond pool size");

  // The tree only ever picks an active server.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tree_idx < active)
    else $error("minimum tree picked an inactive server");

  // A new case always starts at server zero at time zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_adv && a_job_q.new_case) |=> (b_srv_q == '0 && b_start_q == '0))
    else $error("new case did not restart at the first server");

endmodule

@@ tb/earliest_free_server_assign_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the earliest-free-server assignment unit.
// Depends on efsa_pkg and on earliest_free_server_assign_unit with its submodules.
module earliest_free_server_assign_unit_tb;

  localparam int unsigned SRV_W          = efsa_pkg::SRV_W;
  localparam int unsigned DUR_W          = efsa_pkg::DUR_W;
  localparam int unsigned TIME_W         = efsa_pkg::TIME_W;
  localparam int unsigned NUM_SERVERS    = efsa_pkg::MAX_SERVERS_DEF;
  localparam int unsigned PIPE_LATENCY   = 4;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned MAX_REPORTED   = 10;
  localparam int unsigned RANDOM_PHASES  = 6;
  localparam int unsigned PHASE_JOBS     = 120;
  // Full-length jobs on one server to push its finish time far up.
  localparam int unsigned LONG_JOBS      = 40;

  // Clock, reset and block inputs, all known from time zero.
  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  efsa_pkg::in_t    in_data = '0;
  logic             out_ready = 1'b0;
  logic             cfg_valid = 1'b0;
  logic [SRV_W-1:0] cfg_data = '0;

  logic           in_ready;
  logic           out_valid;
  efsa_pkg::out_t out_data;
  logic           cfg_ready;

  // Shadow state of the unit used for prediction.
  efsa_pkg::time_t  shadow_finish [NUM_SERVERS];
  int unsigned      shadow_filled;
  logic [SRV_W-1:0] shadow_count;

  // Predicted assignments still waiting for their result transfer.
  efsa_pkg::out_t pending_assignments[$];

  int unsigned mismatch_count;
  int unsigned jobs_sent;
  int unsigned results_checked;
  int unsigned count_writes;
  int unsigned burst_left;
  int unsigned stall_left;
  int unsigned stall_pct;
  int unsigned quiet_cycles;

  earliest_free_server_assign_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Lowest-indexed server with the smallest finish time among the first n.
  function automatic int unsigned earliest_server(input int unsigned n);
    int unsigned best;
    best = 0;
    for (int unsigned i = 1; i < n; i++) begin
      if (shadow_finish[i] < shadow_finish[best]) begin
        best = i;
      end
    end
    return best;
  endfunction

  // Assigns one job in the shadow state and returns the result it must produce.
  function automatic efsa_pkg::out_t predict_assignment(input efsa_pkg::in_t job);
    int unsigned     active;
    int unsigned     srv;
    int unsigned     nxt;
    efsa_pkg::time_t start;
    logic [TIME_W:0] sum;
    efsa_pkg::out_t  res;
    active = (shadow_count == '0) ? 1 :
             (shadow_count > SRV_W'(NUM_SERVERS)) ? NUM_SERVERS : int'(shadow_count);
    if (job.new_case) begin
      foreach (shadow_finish[i]) shadow_finish[i] = '0;
      shadow_filled = 0;
    end
    if (shadow_filled < active) begin
      srv   = shadow_filled;
      start = '0;
    end else begin
      srv   = earliest_server(active);
      start = shadow_finish[srv];
    end
    // Finish times stick at the top instead of wrapping.
    sum = {1'b0, start} + (TIME_W+1)'(job.duration);
    shadow_finish[srv] = sum[TIME_W] ? efsa_pkg::TIME_MAX : sum[TIME_W-1:0];
    if (shadow_filled < active) begin
      shadow_filled++;
    end
    nxt = (shadow_filled < active) ? shadow_filled : earliest_server(active);
    res.assigned_server = SRV_W'(srv + 1);
    res.start_time      = start;
    res.next_server     = SRV_W'(nxt + 1);
    return res;
  endfunction

  function automatic void note_mismatch(input string what, input efsa_pkg::out_t exp_res,
                                        input efsa_pkg::out_t act_res);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTED) begin
      $display("%0t: %s: expected srv %0d start %0d next %0d, got srv %0d start %0d next %0d",
               $time, what, exp_res.assigned_server, exp_res.start_time,
               exp_res.next_server, act_res.assigned_server, act_res.start_time,
               act_res.next_server);
    end
  endfunction

  // Receiver: stretches of random length, each with its own stall rate.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      case ($urandom_range(0, 4))
        0, 1:    stall_pct = 0;
        2:       stall_pct = 30;
        3:       stall_pct = 60;
        default: stall_pct = 90;
      endcase
      stall_left = $urandom_range(20, 150);
    end
    stall_left--;
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Result checker: each result transfer against the oldest prediction.
  always @(posedge clk) begin
    efsa_pkg::out_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (pending_assignments.size() == 0) begin
        note_mismatch("result with nothing expected", '0, out_data);
      end else begin
        exp_res = pending_assignments.pop_front();
        results_checked++;
        if (out_data.assigned_server != exp_res.assigned_server ||
            out_data.start_time != exp_res.start_time ||
            out_data.next_server != exp_res.next_server) begin
          note_mismatch("result mismatch", exp_res, out_data);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding",
                 pending_assignments.size());
        $display("earliest_free_server_assign_unit_tb: errors");
        $finish;
      end
    end
  end

  // Sends one job; the sender runs in bursts with random gaps between them.
  task automatic send_job(input logic new_case, input logic [DUR_W-1:0] duration);
    efsa_pkg::in_t job;
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 8)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    job.new_case = new_case;
    job.duration = duration;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= job;
    do @(posedge clk); while (!in_ready);
    pending_assignments.push_back(predict_assignment(job));
    jobs_sent++;
  endtask

  // Stops sending and waits for every predicted result to transfer.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_assignments.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(negedge clk);
  endtask

  // Writes the server count once the unit is idle.
  task automatic write_server_count(input logic [SRV_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    shadow_count = value;
    count_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Fill order, earliest-finish choice, duration extremes and a new case.
  task automatic test_fill_and_ties();
    write_server_count(SRV_W'(4));
    send_job(1'b1, 16'd10);
    send_job(1'b0, 16'd5);
    send_job(1'b0, 16'd0);
    send_job(1'b0, 16'hFFFF);
    send_job(1'b0, 16'd0);
    send_job(1'b0, 16'd7);
    send_job(1'b1, 16'd0);
  endtask

  // A count of zero acts as one server; counts past the pool act as the full pool.
  task automatic test_count_limits();
    write_server_count(SRV_W'(0));
    send_job(1'b1, 16'd3);
    send_job(1'b0, 16'd4);
    write_server_count('1);
    for (int unsigned i = 0; i < NUM_SERVERS + 1; i++) begin
      send_job(i == 0, DUR_W'((i % 3) * 5));
    end
  endtask

  // Shrinking the count mid-case restricts the choice to the first servers; the count then returns to the full pool.
  task automatic test_count_shrink();
    write_server_count(SRV_W'(3));
    send_job(1'b0, 16'd2);
    send_job(1'b0, 16'd9);
    send_job(1'b0, 16'd1);
    write_server_count(SRV_W'(NUM_SERVERS));
    send_job(1'b0, 16'd6);
    send_job(1'b0, 16'd0);
  endtask

  // One server fed full-length jobs back to back, so start times carry high.
  task automatic test_long_jobs();
    write_server_count(SRV_W'(1));
    for (int unsigned i = 0; i < LONG_JOBS; i++) begin
      send_job(i == 0, '1);
    end
  endtask

  // Random jobs over several counts, with one full pause inside each phase.
  task automatic test_random_jobs();
    int unsigned       pause_at;
    logic [SRV_W-1:0]  count_val;
    logic [DUR_W-1:0]  dur;
    logic              fresh;
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      count_val = (p == 0) ? SRV_W'(1) :
                  (p == 1) ? SRV_W'(NUM_SERVERS) : SRV_W'($urandom_range(0, 31));
      write_server_count(count_val);
      pause_at = $urandom_range(10, PHASE_JOBS - 10);
      for (int unsigned i = 0; i < PHASE_JOBS; i++) begin
        case ($urandom_range(0, 9))
          0:       dur = '0;
          1:       dur = '1;
          2, 3, 4: dur = DUR_W'($urandom_range(0, 7));
          default: dur = DUR_W'($urandom);
        endcase
        fresh = (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 99) < 4);
        send_job(fresh, dur);
        if (i == pause_at) begin
          wait_drained();
        end
      end
    end
  endtask

  // Test sequence.
  initial begin
    foreach (shadow_finish[i]) shadow_finish[i] = '0;
    shadow_filled = 0;
    shadow_count  = efsa_pkg::SERVER_COUNT_RST;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_fill_and_ties();
    test_count_limits();
    test_count_shrink();
    test_long_jobs();
    test_random_jobs();

    wait_drained();
    repeat (2 * PIPE_LATENCY) @(posedge clk);

    $display("Sent %0d jobs and checked %0d results over %0d server-count writes.",
             jobs_sent, results_checked, count_writes);
    $display("Covered fill order, ties, count clamping, shrink mid-case and long jobs.");
    if (mismatch_count == 0 && pending_assignments.size() == 0) begin
      $display("earliest_free_server_assign_unit_tb: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count,
               pending_assignments.size());
      $display("earliest_free_server_assign_unit_tb: errors");
    end
    $finish;
  end

endmodule

@@ earliest_free_server_assign_unit.f @@
design/efsa_pkg.sv
design/efsa_min_tree.sv
design/earliest_free_server_assign_unit.sv
tb/earliest_free_server_assign_unit_tb.sv
